@@ hw/rtl/sfa_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// sfa_pkg
// Shared types, command and status codes for the segment field accumulator.
// ----------------------------------------------------------------------------
package sfa_pkg;

  localparam int unsigned NumPointsDef = 1024;
  localparam int unsigned AccWidthDef  = 48;
  localparam int unsigned FracBitsDef  = 16;

  localparam int unsigned CoordW = 32;
  localparam int unsigned IndexW = 10;
  localparam int unsigned OutW   = 48;
  localparam int unsigned CmdW   = 2;
  localparam int unsigned StatW  = 2;

  localparam logic [63:0] Ln2Q28 = 64'h0B17217F;

  typedef enum logic [1:0] {
    CMD_ACC   = 2'd0,
    CMD_READ  = 2'd1,
    CMD_CLEAR = 2'd2,
    CMD_SPARE = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_DEGEN = 2'd1,
    ST_SAT   = 2'd2
  } status_e;

  // operation selector for the shared serial unit
  typedef enum logic [1:0] {
    OP_MULDIV = 2'd0,
    OP_SQRT   = 2'd1,
    OP_LOG    = 2'd2
  } op_e;

  typedef struct packed {
    logic       start;
    op_e        op;
  } su_ctrl_t;

  typedef struct packed {
    logic busy;
    logic done;
    logic sat;
  } su_stat_t;

  function automatic logic [63:0] mag64(input logic signed [63:0] v);
    mag64 = v[63] ? (64'd0 - v) : v;
  endfunction

endpackage : sfa_pkg
`default_nettype wire

@@ hw/rtl/sfa_req_if.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// sfa_req_if
// Request channel: one segment, read or clear command.
// ----------------------------------------------------------------------------
interface sfa_req_if;
  import sfa_pkg::*;
  logic                      valid;
  logic                      ready;
  logic [CmdW-1:0]           command;
  logic signed [CoordW-1:0]  start_x;
  logic signed [CoordW-1:0]  start_y;
  logic signed [CoordW-1:0]  start_z;
  logic signed [CoordW-1:0]  end_x;
  logic signed [CoordW-1:0]  end_y;
  logic signed [CoordW-1:0]  end_z;
  logic signed [CoordW-1:0]  segment_current;
  logic [IndexW-1:0]         point_index;

  modport source (output valid, command, start_x, start_y, start_z, end_x, end_y,
                  end_z, segment_current, point_index, input ready);
  modport sink   (input valid, command, start_x, start_y, start_z, end_x, end_y,
                  end_z, segment_current, point_index, output ready);
endinterface : sfa_req_if
`default_nettype wire

@@ hw/rtl/sfa_rsp_if.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// sfa_rsp_if
// Response channel: updated totals of one observation point.
// ----------------------------------------------------------------------------
interface sfa_rsp_if;
  import sfa_pkg::*;
  logic                   valid;
  logic                   ready;
  logic signed [OutW-1:0] potential_x;
  logic signed [OutW-1:0] potential_y;
  logic signed [OutW-1:0] potential_z;
  logic signed [OutW-1:0] flux_x;
  logic signed [OutW-1:0] flux_y;
  logic signed [OutW-1:0] flux_z;
  logic [IndexW-1:0]      result_index;
  logic [StatW-1:0]       status;

  modport source (output valid, potential_x, potential_y, potential_z, flux_x, flux_y,
                  flux_z, result_index, status, input ready);
  modport sink   (input valid, potential_x, potential_y, potential_z, flux_x, flux_y,
                  flux_z, result_index, status, output ready);
endinterface : sfa_rsp_if
`default_nettype wire

@@ hw/rtl/sfa_ram.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// sfa_ram
// Generic single-port RAM with registered read.
// ----------------------------------------------------------------------------
module sfa_ram #(
  parameter int unsigned Width = 48,
  parameter int unsigned Depth = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] addr_i,
  input  wire logic [Width-1:0]         wdata_i,
  output logic      [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    rdata_o <= mem[addr_i];
  end
endmodule : sfa_ram
`default_nettype wire

@@ hw/rtl/sfa_serial_unit.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// sfa_serial_unit
// Shared bit-serial unit: x*y/z with saturation, integer square root and
// log2 in Q.28, one bit per cycle.
// ----------------------------------------------------------------------------
module sfa_serial_unit
  import sfa_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire su_ctrl_t           ctrl_i,
  input  wire logic signed [63:0] x_i,
  input  wire logic signed [63:0] y_i,
  input  wire logic [63:0]        z_i,
  output su_stat_t                stat_o,
  output logic signed [63:0]      res_o
);
  typedef enum logic [2:0] {
    S_IDLE, S_MUL, S_DIV, S_SQRT, S_LOGN, S_LOGF, S_DONE
  } state_e;

  state_e       state_q;
  op_e          op_q;
  logic [6:0]   cnt_q;
  logic         neg_q, sat_q;
  logic [63:0]  a_q, b_q, z_q;
  logic [127:0] p_q;
  logic [63:0]  r_q, q_q;
  logic [63:0]  m_q;
  logic [63:0]  mm;
  logic [64:0]  rsh;
  logic [63:0]  sq_t;

  // one squaring step of the log mantissa, 33-bit operand
  assign mm   = 64'((m_q[32:0] * m_q[32:0]) >> 31);
  assign rsh  = {r_q, p_q[127]};
  assign sq_t = q_q + z_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      op_q    <= OP_MULDIV;
      cnt_q   <= '0;
      neg_q   <= 1'b0;
      sat_q   <= 1'b0;
      a_q     <= '0;
      b_q     <= '0;
      z_q     <= '0;
      p_q     <= '0;
      r_q     <= '0;
      q_q     <= '0;
      m_q     <= '0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (ctrl_i.start) begin
            op_q  <= ctrl_i.op;
            sat_q <= 1'b0;
            q_q   <= '0;
            r_q   <= '0;
            cnt_q <= '0;
            unique case (ctrl_i.op)
              OP_MULDIV: begin
                neg_q   <= x_i[63] ^ y_i[63];
                a_q     <= mag64(x_i);
                b_q     <= mag64(y_i);
                z_q     <= (z_i == 64'd0) ? 64'd1 : z_i;
                p_q     <= '0;
                state_q <= S_MUL;
              end
              OP_SQRT: begin
                a_q     <= x_i;
                z_q     <= 64'h4000_0000_0000_0000;
                state_q <= S_SQRT;
              end
              default: begin
                a_q     <= x_i;
                state_q <= S_LOGN;
              end
            endcase
          end
        end
        S_MUL: begin
          // shift-add multiply, msb of b first
          p_q   <= (p_q << 1) + (b_q[63] ? {64'd0, a_q} : 128'd0);
          b_q   <= b_q << 1;
          cnt_q <= cnt_q + 7'd1;
          if (cnt_q == 7'd63) begin
            cnt_q   <= '0;
            state_q <= S_DIV;
          end
        end
        S_DIV: begin
          if (cnt_q == 7'd0 && p_q[127:64] >= z_q) begin
            sat_q   <= 1'b1;
            q_q     <= 64'h7FFF_FFFF_FFFF_FFFF;
            state_q <= S_DONE;
          end else begin
            if (rsh >= {1'b0, z_q}) begin
              r_q <= 64'(rsh - {1'b0, z_q});
              q_q <= {q_q[62:0], 1'b1};
            end else begin
              r_q <= rsh[63:0];
              q_q <= {q_q[62:0], 1'b0};
            end
            if (cnt_q == 7'd0) begin
              r_q <= p_q[127:64];
              q_q <= '0;
              p_q <= {p_q[63:0], 64'd0};
              cnt_q <= 7'd1;
            end else begin
              p_q   <= p_q << 1;
              cnt_q <= cnt_q + 7'd1;
              if (cnt_q == 7'd64) begin
                state_q <= S_DONE;
              end
            end
          end
        end
        S_SQRT: begin
          // z_q holds the current bit, q_q the root
          if (z_q == 64'd0) begin
            state_q <= S_DONE;
          end else if (a_q >= sq_t) begin
            a_q <= a_q - sq_t;
            q_q <= (q_q >> 1) + z_q;
            z_q <= z_q >> 2;
          end else begin
            q_q <= q_q >> 1;
            z_q <= z_q >> 2;
          end
        end
        S_LOGN: begin
          // normalize one bit per cycle: exponent in r_q
          if (a_q[63:1] != 63'd0) begin
            a_q <= a_q >> 1;
            r_q <= r_q + 64'd1;
          end else begin
            state_q <= S_LOGF;
          end
          if (cnt_q == 7'd0) begin
            m_q   <= x_i;
            cnt_q <= 7'd1;
          end
        end
        S_LOGF: begin
          if (cnt_q == 7'd1) begin
            // build Q1.31 mantissa from the original value
            m_q   <= (r_q > 64'd31) ? (m_q >> (r_q - 64'd31)) : (m_q << (64'd31 - r_q));
            cnt_q <= 7'd2;
          end else begin
            q_q <= {q_q[62:0], mm[32]};
            m_q <= mm[32] ? (mm >> 1) : mm;
            cnt_q <= cnt_q + 7'd1;
            if (cnt_q == 7'd29) begin
              state_q <= S_DONE;
            end
          end
        end
        S_DONE: begin
          state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  logic [63:0] qsat;
  always_comb begin
    qsat = q_q;
    if (op_q == OP_MULDIV && q_q[63]) begin
      qsat = 64'h7FFF_FFFF_FFFF_FFFF;
    end
    unique case (op_q)
      OP_MULDIV: res_o = neg_q ? (64'd0 - qsat) : qsat;
      OP_SQRT:   res_o = q_q;
      default:   res_o = {r_q[35:0], q_q[27:0]};
    endcase
  end

  // the S_LOGN stage latches the raw value on its first cycle only; the
  // shift register a_q counts the exponent from the same value
  assign stat_o.busy = (state_q != S_IDLE);
  assign stat_o.done = (state_q == S_DONE);
  assign stat_o.sat  = sat_q || (op_q == OP_MULDIV && q_q[63]);
endmodule : sfa_serial_unit
`default_nettype wire

@@ hw/rtl/segment_field_accumulator_top.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// segment_field_accumulator_top
// Line-segment vector potential and flux terms, accumulated per point.
// ----------------------------------------------------------------------------
//  channel   dir  handshake      payload
//  req_i     in   valid/ready    command, endpoints, current, point index
//  rsp_o     out  valid/ready    six totals, result index, status
//
//  a read or a clear first reduces the point index modulo NUM_POINTS, then reads
//  the totals row; a clear writes the zeroed row back before it answers. an
//  accumulate runs the shared serial unit through three roots, two logs and
//  twenty product-quotients, one at a time.
//  after reset the totals store is swept to zero, one point per cycle, while
//  no request is taken. a stalled response holds.
// ----------------------------------------------------------------------------
module segment_field_accumulator_top
  import sfa_pkg::*;
#(
  parameter int unsigned NUM_POINTS = NumPointsDef,
  parameter int unsigned ACC_WIDTH  = AccWidthDef,
  parameter int unsigned FRAC_BITS  = FracBitsDef
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  sfa_req_if.sink   req_i,
  sfa_rsp_if.source rsp_o
);
  localparam int unsigned AW = (NUM_POINTS > 1) ? $clog2(NUM_POINTS) : 1;
  localparam int unsigned RD = (NUM_POINTS > 1) ? NUM_POINTS : 2;
  localparam int unsigned RowW = 3 * ACC_WIDTH;
  localparam logic signed [63:0] AccHi = 64'((65'd1 << (ACC_WIDTH - 1)) - 65'd1);
  localparam logic signed [63:0] AccLo = -AccHi - 64'sd1;

  typedef enum logic [4:0] {
    T_CLR, T_IDLE, T_MOD, T_RD, T_RDW, T_PREP, T_CHK, T_SQA, T_SQB, T_SQD, T_DOTS,
    T_LGN, T_LGD, T_LN, T_KF, T_U, T_T, T_V, T_W, T_IP, T_IF, T_SUM, T_WR, T_OUT
  } state_e;

  state_e state_q;
  logic [AW-1:0] addr_q;
  logic [AW:0]   sweep_q;
  logic [IndexW-1:0] idx_q;
  logic [3:0]    mcnt_q;
  logic [1:0]    cmd_q;
  logic [1:0]    ax_q;
  logic [3:0]    sh_q;
  logic          sat_q, degen_q;
  logic signed [CoordW-1:0] raw_q [6];
  logic signed [CoordW-1:0] cur_q;
  logic signed [23:0] sa_q [3];
  logic signed [23:0] sb_q [3];
  logic signed [24:0] dv_q [3];
  logic signed [63:0] cr_q [3];
  logic signed [63:0] na_q, nb_q, nd_q, num_q, den_q, den1_q;
  logic signed [63:0] lg_q, lnr_q, kf_q, u_q, t_q, v_q, w_q;
  logic signed [63:0] ip_q [3];
  logic signed [63:0] if_q [3];
  logic signed [ACC_WIDTH-1:0] pot_q [3];
  logic signed [ACC_WIDTH-1:0] flx_q [3];
  logic [IndexW-1:0] ridx_q;
  logic [1:0] stat_q;
  logic rvalid_q;

  // index reduction, one compare and subtract per cycle
  logic [26:0]       nshift;
  logic [IndexW-1:0] idx_red;
  assign nshift  = 27'(NUM_POINTS) << mcnt_q;
  assign idx_red = (27'(idx_q) >= nshift) ? IndexW'(27'(idx_q) - nshift) : idx_q;

  // ram
  logic              ram_we;
  logic [AW-1:0]     ram_addr;
  logic [RowW-1:0]   pw_d, fw_d, pr, fr;

  sfa_ram #(.Width(RowW), .Depth(RD)) u_pot (
    .clk_i(clk_i), .we_i(ram_we), .addr_i(ram_addr), .wdata_i(pw_d), .rdata_o(pr));
  sfa_ram #(.Width(RowW), .Depth(RD)) u_flx (
    .clk_i(clk_i), .we_i(ram_we), .addr_i(ram_addr), .wdata_i(fw_d), .rdata_o(fr));

  assign ram_addr = (state_q == T_CLR) ? sweep_q[AW-1:0] : addr_q;
  assign ram_we   = (state_q == T_CLR) || (state_q == T_WR);
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      pw_d[i*ACC_WIDTH +: ACC_WIDTH] = (state_q == T_CLR) ? '0 : pot_q[i];
      fw_d[i*ACC_WIDTH +: ACC_WIDTH] = (state_q == T_CLR) ? '0 : flx_q[i];
    end
  end

  // serial unit
  su_ctrl_t su_ctrl;
  su_stat_t su_stat;
  logic signed [63:0] su_x, su_y, su_res;
  logic [63:0] su_z;
  logic su_go_q;

  sfa_serial_unit u_su (
    .clk_i(clk_i), .rst_ni(rst_ni), .ctrl_i(su_ctrl), .x_i(su_x), .y_i(su_y),
    .z_i(su_z), .stat_o(su_stat), .res_o(su_res));

  logic signed [63:0] sqa, sqb, sqd, dotb, dota, dotab;
  always_comb begin
    sqa = '0; sqb = '0; sqd = '0; dotb = '0; dota = '0; dotab = '0;
    for (int i = 0; i < 3; i++) begin
      sqa   = sqa + 64'(sa_q[i] * sa_q[i]);
      sqb   = sqb + 64'(sb_q[i] * sb_q[i]);
      sqd   = sqd + 64'(dv_q[i] * dv_q[i]);
      dotb  = dotb + 64'(sb_q[i] * dv_q[i]);
      dota  = dota + 64'(sa_q[i] * dv_q[i]);
      dotab = dotab + 64'(sa_q[i] * sb_q[i]);
    end
  end

  always_comb begin
    su_ctrl.start = su_go_q;
    su_ctrl.op    = OP_MULDIV;
    su_x = '0; su_y = '0; su_z = 64'd1;
    unique case (state_q)
      T_SQA: begin su_ctrl.op = OP_SQRT; su_x = sqa; end
      T_SQB: begin su_ctrl.op = OP_SQRT; su_x = sqb; end
      T_SQD: begin su_ctrl.op = OP_SQRT; su_x = sqd; end
      T_LGN: begin su_ctrl.op = OP_LOG;  su_x = num_q; end
      T_LGD: begin su_ctrl.op = OP_LOG;  su_x = den_q; end
      T_LN:  begin su_x = lg_q; su_y = Ln2Q28; su_z = 64'd1 << 28; end
      T_KF:  begin su_x = na_q + nb_q; su_y = 64'sd1 << 40; su_z = den1_q; end
      T_U:   begin su_x = 64'(dv_q[ax_q]); su_y = 64'sd1 << 30; su_z = nd_q; end
      T_T:   begin su_x = lnr_q; su_y = u_q; su_z = 64'd1 << 34; end
      T_V:   begin
        su_x = cr_q[ax_q]; su_y = 64'sd1 << 40; su_z = 64'(na_q[31:0] * nb_q[31:0]);
      end
      T_W:   begin su_x = kf_q; su_y = v_q; su_z = 64'd1 << (7'd40 + 7'(sh_q)); end
      T_IP:  begin su_x = t_q; su_y = 64'(cur_q); su_z = 64'd1 << FRAC_BITS; end
      T_IF:  begin su_x = 64'(cur_q); su_y = w_q; su_z = 64'd1 << 16; end
      default: ;
    endcase
  end

  function automatic logic signed [ACC_WIDTH-1:0] accadd(
    input logic signed [ACC_WIDTH-1:0] acc, input logic signed [63:0] inc,
    output logic sat);
    logic signed [65:0] s;
    s   = 66'(acc) + 66'(inc);
    sat = 1'b0;
    if (s > 66'(AccHi)) begin sat = 1'b1; accadd = AccHi[ACC_WIDTH-1:0]; end
    else if (s < 66'(AccLo)) begin sat = 1'b1; accadd = AccLo[ACC_WIDTH-1:0]; end
    else accadd = s[ACC_WIDTH-1:0];
  endfunction

  logic [31:0] mxv;
  always_comb begin
    mxv = '0;
    for (int i = 0; i < 6; i++) begin
      if (32'(mag64(64'(raw_q[i]))) > mxv) mxv = 32'(mag64(64'(raw_q[i])));
    end
  end

  logic s0, s1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= T_CLR;
      sweep_q  <= '0;
      rvalid_q <= 1'b0;
      su_go_q  <= 1'b0;
      addr_q   <= '0;
      idx_q    <= '0;
      mcnt_q   <= '0;
      cmd_q    <= '0;
      ax_q     <= '0;
      sh_q     <= '0;
      sat_q    <= 1'b0;
      degen_q  <= 1'b0;
    end else begin
      su_go_q <= 1'b0;
      if (rvalid_q && rsp_o.ready) rvalid_q <= 1'b0;
      unique case (state_q)
        T_CLR: begin
          sweep_q <= sweep_q + 1'b1;
          if (sweep_q == (AW+1)'(RD - 1)) state_q <= T_IDLE;
        end
        T_IDLE: begin
          if (req_i.valid && !rvalid_q) begin
            cmd_q   <= req_i.command;
            idx_q   <= req_i.point_index;
            mcnt_q  <= 4'(IndexW - 1);
            raw_q[0] <= req_i.start_x; raw_q[1] <= req_i.start_y;
            raw_q[2] <= req_i.start_z; raw_q[3] <= req_i.end_x;
            raw_q[4] <= req_i.end_y;   raw_q[5] <= req_i.end_z;
            cur_q   <= req_i.segment_current;
            sat_q   <= 1'b0;
            degen_q <= 1'b0;
            sh_q    <= '0;
            state_q <= T_MOD;
          end
        end
        T_MOD: begin
          idx_q <= idx_red;
          if (mcnt_q == 4'd0) begin
            addr_q  <= AW'(idx_red);
            state_q <= T_RD;
          end else begin
            mcnt_q <= mcnt_q - 4'd1;
          end
        end
        T_RD: state_q <= T_RDW;
        T_RDW: begin
          for (int i = 0; i < 3; i++) begin
            pot_q[i] <= pr[i*ACC_WIDTH +: ACC_WIDTH];
            flx_q[i] <= fr[i*ACC_WIDTH +: ACC_WIDTH];
          end
          unique case (cmd_q)
            CMD_CLEAR: begin
              for (int i = 0; i < 3; i++) begin pot_q[i] <= '0; flx_q[i] <= '0; end
              state_q <= T_WR;
            end
            CMD_ACC: state_q <= T_PREP;
            default: state_q <= T_OUT;
          endcase
        end
        T_PREP: begin
          // one shift step per cycle
          if ((mxv >> sh_q) >= 32'h0080_0000) begin
            sh_q <= sh_q + 4'd1;
          end else begin
            for (int i = 0; i < 3; i++) begin
              sa_q[i] <= 24'(raw_q[i] >>> sh_q);
              sb_q[i] <= 24'(raw_q[i+3] >>> sh_q);
              dv_q[i] <= 25'(raw_q[i+3] >>> sh_q) - 25'(raw_q[i] >>> sh_q);
            end
            state_q <= T_CHK;
          end
        end
        T_CHK: begin
          cr_q[0] <= 64'(sa_q[1] * sb_q[2]) - 64'(sa_q[2] * sb_q[1]);
          cr_q[1] <= 64'(sa_q[2] * sb_q[0]) - 64'(sa_q[0] * sb_q[2]);
          cr_q[2] <= 64'(sa_q[0] * sb_q[1]) - 64'(sa_q[1] * sb_q[0]);
          if ((dv_q[0] | dv_q[1] | dv_q[2]) == 25'd0) begin
            degen_q <= 1'b1;
            state_q <= T_OUT;
          end else begin
            state_q <= T_SQA;
            su_go_q <= 1'b1;
          end
        end
        T_SQA: if (su_stat.done) begin
          if ((cr_q[0] | cr_q[1] | cr_q[2]) == 64'd0) begin
            degen_q <= 1'b1; state_q <= T_OUT;
          end else begin
            na_q <= su_res; state_q <= T_SQB; su_go_q <= 1'b1;
          end
        end
        T_SQB: if (su_stat.done) begin nb_q <= su_res; state_q <= T_SQD; su_go_q <= 1'b1; end
        T_SQD: if (su_stat.done) begin nd_q <= su_res; state_q <= T_DOTS; end
        T_DOTS: begin
          num_q  <= 64'(nb_q[31:0] * nd_q[31:0]) + dotb;
          den_q  <= 64'(na_q[31:0] * nd_q[31:0]) + dota;
          den1_q <= 64'(na_q[31:0] * nb_q[31:0]) + dotab;
          state_q <= T_LGN;
          su_go_q <= 1'b1;
        end
        T_LGN: if (su_stat.done) begin
          if (num_q <= 0 || den_q <= 0 || den1_q <= 0 || na_q <= 0 || nb_q <= 0) begin
            degen_q <= 1'b1; state_q <= T_OUT;
          end else begin
            lg_q <= su_res; state_q <= T_LGD; su_go_q <= 1'b1;
          end
        end
        T_LGD: if (su_stat.done) begin
          lg_q <= lg_q - su_res; state_q <= T_LN; su_go_q <= 1'b1;
        end
        T_LN: if (su_stat.done) begin
          sat_q <= sat_q | su_stat.sat; lnr_q <= su_res; state_q <= T_KF; su_go_q <= 1'b1;
        end
        T_KF: if (su_stat.done) begin
          sat_q <= sat_q | su_stat.sat; kf_q <= su_res; ax_q <= '0;
          state_q <= T_U; su_go_q <= 1'b1;
        end
        T_U: if (su_stat.done) begin
          sat_q <= sat_q | su_stat.sat; u_q <= su_res; state_q <= T_T; su_go_q <= 1'b1;
        end
        T_T: if (su_stat.done) begin
          sat_q <= sat_q | su_stat.sat; t_q <= su_res; state_q <= T_V; su_go_q <= 1'b1;
        end
        T_V: if (su_stat.done) begin
          sat_q <= sat_q | su_stat.sat; v_q <= su_res; state_q <= T_W; su_go_q <= 1'b1;
        end
        T_W: if (su_stat.done) begin
          sat_q <= sat_q | su_stat.sat; w_q <= su_res; state_q <= T_IP; su_go_q <= 1'b1;
        end
        T_IP: if (su_stat.done) begin
          sat_q <= sat_q | su_stat.sat; ip_q[ax_q] <= su_res; state_q <= T_IF;
          su_go_q <= 1'b1;
        end
        T_IF: if (su_stat.done) begin
          sat_q <= sat_q | su_stat.sat; if_q[ax_q] <= su_res;
          if (ax_q == 2'd2) begin
            ax_q <= '0; state_q <= T_SUM;
          end else begin
            ax_q <= ax_q + 2'd1; state_q <= T_U; su_go_q <= 1'b1;
          end
        end
        T_SUM: begin
          // one axis per cycle
          pot_q[ax_q] <= accadd(pot_q[ax_q], ip_q[ax_q], s0);
          flx_q[ax_q] <= accadd(flx_q[ax_q], if_q[ax_q], s1);
          sat_q <= sat_q | s0 | s1;
          if (ax_q == 2'd2) state_q <= T_WR;
          else ax_q <= ax_q + 2'd1;
        end
        T_WR: state_q <= T_OUT;
        T_OUT: begin
          ridx_q   <= IndexW'(addr_q);
          stat_q   <= degen_q ? ST_DEGEN : (sat_q ? ST_SAT : ST_OK);
          rvalid_q <= 1'b1;
          state_q  <= T_IDLE;
        end
        default: state_q <= T_IDLE;
      endcase
    end
  end

  assign req_i.ready       = (state_q == T_IDLE) && !rvalid_q;
  assign rsp_o.valid       = rvalid_q;
  assign rsp_o.potential_x = OutW'(pot_q[0]);
  assign rsp_o.potential_y = OutW'(pot_q[1]);
  assign rsp_o.potential_z = OutW'(pot_q[2]);
  assign rsp_o.flux_x      = OutW'(flx_q[0]);
  assign rsp_o.flux_y      = OutW'(flx_q[1]);
  assign rsp_o.flux_z      = OutW'(flx_q[2]);
  assign rsp_o.result_index = ridx_q;
  assign rsp_o.status      = stat_q;
endmodule : segment_field_accumulator_top
`default_nettype wire
